>>> rtl/noc_rc_pkg.sv
// ----------------------------------------------------------------------------
// noc_rc_pkg
// Shared types and codes of the route computation unit.
// ----------------------------------------------------------------------------
package noc_rc_pkg;

  typedef enum logic [1:0] {
    SCHEME_RING  = 2'd0,
    SCHEME_TWO   = 2'd1,
    SCHEME_MESH  = 2'd2,
    SCHEME_TORUS = 2'd3
  } scheme_e;

  // Register index (byte address divided by four)
  typedef enum logic [1:0] {
    REG_SCHEME = 2'd0,
    REG_OWN    = 2'd1,
    REG_GRID   = 2'd2,
    REG_RING   = 2'd3
  } reg_e;

  localparam logic [2:0] PORT_EJECT   = 3'd0;
  localparam logic [2:0] PORT_X_MINUS = 3'd1;
  localparam logic [2:0] PORT_X_PLUS  = 3'd2;
  localparam logic [2:0] PORT_Y_MINUS = 3'd3;
  localparam logic [2:0] PORT_Y_PLUS  = 3'd4;

  localparam logic OP_COMPUTE = 1'b0;
  localparam logic OP_LOOKUP  = 1'b1;

  // Live configuration as seen by the datapath (sizes already clamped)
  typedef struct packed {
    scheme_e    scheme;
    logic [7:0] own_node;
    logic [8:0] grid;
    logic [8:0] ring;
  } cfg_t;

  typedef struct packed {
    logic       op_mode;
    logic [2:0] in_channel;
    logic [7:0] dest_node;
    logic       is_response;
    logic       is_proc_request;
  } req_t;

  // First division: node number by the scheme's divisor
  typedef struct packed {
    logic [8:0] own_rem;
    logic [8:0] dest_rem;
    logic [7:0] own_quo;
    logic [7:0] dest_quo;
  } div_t;

  typedef struct packed {
    logic [2:0] port;
    logic [2:0] vc;
    logic       ok;
  } route_t;

  typedef struct packed {
    logic [2:0] egress_port;
    logic [2:0] out_vc;
    logic       entry_valid;
    logic       route_error;
    logic       none_valid;
  } result_t;

endpackage

>>> rtl/noc_rc_div4.sv
// ----------------------------------------------------------------------------
// noc_rc_div4
// Four restoring division steps: takes four dividend bits, MSB first.
// ----------------------------------------------------------------------------
module noc_rc_div4 (
  input  logic [8:0] rem_i,
  input  logic [3:0] bits_i,
  input  logic [8:0] divisor_i,
  output logic [8:0] rem_o,
  output logic [3:0] quo_o
);

  always_comb begin
    logic [9:0] trial;
    logic [8:0] rem;
    rem   = rem_i;
    quo_o = '0;
    for (int k = 3; k >= 0; k--) begin
      trial = {rem, bits_i[k]};
      if (trial >= {1'b0, divisor_i}) begin
        rem      = 9'(trial - {1'b0, divisor_i});
        quo_o[k] = 1'b1;
      end else begin
        rem = trial[8:0];
      end
    end
    rem_o = rem;
  end

endmodule

>>> rtl/noc_rc_route.sv
// ----------------------------------------------------------------------------
// noc_rc_route
// Route selection from the divided coordinates under the active scheme.
// ----------------------------------------------------------------------------
module noc_rc_route (
  input  noc_rc_pkg::cfg_t   cfg_i,
  input  noc_rc_pkg::req_t   req_i,
  input  noc_rc_pkg::div_t   div_i,
  input  logic [8:0]         own_rem_b_i,
  input  logic [8:0]         dest_rem_b_i,
  output noc_rc_pkg::route_t route_o
);

  // Shorter way round one dimension: 1 selects the minus port
  function automatic logic go_minus(logic [8:0] me, logic [8:0] dst, logic [8:0] size);
    logic [8:0] half;
    half = size >> 1;
    if (dst > me) return (dst - me) > half;
    return !((me - dst) > half);
  endfunction

  // Wrap mirror of a value already reduced modulo size
  function automatic logic [8:0] mirror(logic [8:0] xm, logic [8:0] size);
    return (xm == '0) ? '0 : size - xm;
  endfunction

  always_comb begin
    logic [8:0] own9;
    logic [8:0] dst9;
    logic [8:0] oq9;
    logic [8:0] dq9;
    logic       same_x;
    logic       same_xy;
    logic       cmp;
    own9    = {1'b0, cfg_i.own_node};
    dst9    = {1'b0, req_i.dest_node};
    oq9     = {1'b0, div_i.own_quo};
    dq9     = {1'b0, div_i.dest_quo};
    same_x  = div_i.own_rem == div_i.dest_rem;
    same_xy = same_x && (div_i.own_quo == div_i.dest_quo);
    cmp     = 1'b0;
    route_o = '{port: noc_rc_pkg::PORT_EJECT, vc: 3'd0, ok: 1'b1};

    unique case (cfg_i.scheme)
      noc_rc_pkg::SCHEME_RING: begin
        if (own9 != dst9) begin
          if (go_minus(own9, dst9, cfg_i.ring)) begin
            route_o.port = noc_rc_pkg::PORT_X_MINUS;
            cmp = mirror(div_i.dest_rem, cfg_i.ring) > mirror(div_i.own_rem, cfg_i.ring);
          end else begin
            route_o.port = noc_rc_pkg::PORT_X_PLUS;
            cmp = dst9 > own9;
          end
        end
        if (cmp) route_o.vc = req_i.is_proc_request ? 3'd2 : 3'd3;
        else     route_o.vc = req_i.is_proc_request ? 3'd0 : 3'd1;
      end
      noc_rc_pkg::SCHEME_TWO: begin
        route_o.vc = req_i.is_proc_request ? 3'd0 : 3'd1;
        if (cfg_i.own_node == 8'd0) begin
          if (req_i.dest_node == 8'd1) route_o.port = noc_rc_pkg::PORT_X_MINUS;
        end else if (cfg_i.own_node == 8'd1) begin
          if (req_i.dest_node == 8'd0) route_o.port = noc_rc_pkg::PORT_X_MINUS;
        end else begin
          route_o.ok = 1'b0;
        end
      end
      noc_rc_pkg::SCHEME_MESH: begin
        if (same_xy)     route_o.port = noc_rc_pkg::PORT_EJECT;
        else if (same_x) route_o.port = (dq9 < oq9) ? noc_rc_pkg::PORT_Y_MINUS
                                                    : noc_rc_pkg::PORT_Y_PLUS;
        else             route_o.port = (div_i.dest_rem < div_i.own_rem)
                                        ? noc_rc_pkg::PORT_X_MINUS
                                        : noc_rc_pkg::PORT_X_PLUS;
      end
      noc_rc_pkg::SCHEME_TORUS: begin
        if (same_xy) begin
          route_o.vc = req_i.is_response ? 3'd1 : 3'd0;
        end else if (same_x) begin
          if (go_minus(oq9, dq9, cfg_i.grid)) begin
            route_o.port = noc_rc_pkg::PORT_Y_MINUS;
            cmp = mirror(dest_rem_b_i, cfg_i.grid) > mirror(own_rem_b_i, cfg_i.grid);
          end else begin
            route_o.port = noc_rc_pkg::PORT_Y_PLUS;
            cmp = dq9 > oq9;
          end
          if (cmp) route_o.vc = req_i.is_response ? 3'd3 : 3'd4;
          else     route_o.vc = req_i.is_response ? 3'd1 : 3'd0;
        end else begin
          if (go_minus(div_i.own_rem, div_i.dest_rem, cfg_i.grid)) begin
            route_o.port = noc_rc_pkg::PORT_X_MINUS;
            cmp = mirror(div_i.dest_rem, cfg_i.grid) > mirror(div_i.own_rem, cfg_i.grid);
          end else begin
            route_o.port = noc_rc_pkg::PORT_X_PLUS;
            cmp = div_i.dest_rem > div_i.own_rem;
          end
          if (cmp) route_o.vc = req_i.is_response ? 3'd3 : 3'd2;
          else     route_o.vc = req_i.is_response ? 3'd1 : 3'd0;
        end
      end
      default: route_o.ok = 1'b0;
    endcase
  end

endmodule

>>> rtl/noc_rc_table.sv
// ----------------------------------------------------------------------------
// noc_rc_table
// Per-VC route entries: write on compute, read on lookup, any-valid flag.
// ----------------------------------------------------------------------------
module noc_rc_table #(
  parameter int NUM_VCS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                commit_i,
  input  noc_rc_pkg::req_t    req_i,
  input  noc_rc_pkg::route_t  route_i,
  output noc_rc_pkg::result_t result_o
);

  localparam int IdxW = (NUM_VCS > 1) ? $clog2(NUM_VCS) : 1;

  logic [2:0]         port_q [NUM_VCS];
  logic [2:0]         vc_q   [NUM_VCS];
  logic [NUM_VCS-1:0] valid_q;

  logic            in_range;
  logic            wr;
  logic [IdxW-1:0] idx;

  assign in_range = int'(req_i.in_channel) < NUM_VCS;
  assign idx      = IdxW'(req_i.in_channel);
  assign wr       = in_range && (req_i.op_mode == noc_rc_pkg::OP_COMPUTE) && route_i.ok;

  always_comb begin
    result_o            = '0;
    result_o.none_valid = ~|valid_q;
    if (!in_range) begin
      result_o.route_error = 1'b1;
    end else if (wr) begin
      result_o.egress_port = route_i.port;
      result_o.out_vc      = route_i.vc;
      result_o.entry_valid = 1'b1;
      result_o.none_valid  = 1'b0;
    end else begin
      result_o.egress_port = port_q[idx];
      result_o.out_vc      = vc_q[idx];
      result_o.entry_valid = valid_q[idx];
      result_o.route_error = (req_i.op_mode == noc_rc_pkg::OP_COMPUTE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < NUM_VCS; i++) begin
        port_q[i] <= '0;
        vc_q[i]   <= '0;
      end
    end else if (commit_i && wr) begin
      port_q[idx]  <= route_i.port;
      vc_q[idx]    <= route_i.vc;
      valid_q[idx] <= 1'b1;
    end
  end

endmodule

>>> rtl/noc_route_compute_unit.sv
// ----------------------------------------------------------------------------
// noc_route_compute_unit
// Route computation for one router: per-VC route entries, four schemes.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  moves
//  request   in         in_valid_i / in_stall_o    compute or lookup request
//  result    out        out_valid_o / out_stall_i  port, VC and status flags
//  config    in         APB (psel..pready)         routing registers
//
//  One request per cycle while in_stall_o is low; each result passes all stages.
//  Stages: two for node / divisor, two for row / grid (torus mirror), one for
//  route selection and the entry write into the output register.
//  Every stage holds under stall and fills its bubble; entries are cleared
//  by reset.
// ----------------------------------------------------------------------------
module noc_route_compute_unit #(
  parameter int NUM_VCS   = 8,
  parameter int MAX_NODES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_mode_i,
  input  logic [2:0]  in_channel_i,
  input  logic [7:0]  dest_node_i,
  input  logic        is_response_i,
  input  logic        is_proc_request_i,
  // results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  egress_port_o,
  output logic [2:0]  out_vc_o,
  output logic        entry_valid_o,
  output logic        route_error_o,
  output logic        none_valid_o
);

  localparam logic [10:0] MaxNodes = 11'(MAX_NODES);

  typedef struct packed {
    noc_rc_pkg::req_t req;
    logic [8:0]       own_rem;
    logic [8:0]       dest_rem;
    logic [3:0]       own_qh;
    logic [3:0]       dest_qh;
  } stage_a_t;

  typedef struct packed {
    noc_rc_pkg::req_t req;
    noc_rc_pkg::div_t div;
  } stage_q_t;

  typedef struct packed {
    noc_rc_pkg::req_t req;
    noc_rc_pkg::div_t div;
    logic [8:0]       own_rem_b;
    logic [8:0]       dest_rem_b;
  } stage_b_t;

  // ---------------------------------------------------------------- config
  noc_rc_pkg::scheme_e scheme_q;
  logic [7:0]          own_q;
  logic [4:0]          grid_q;
  logic [8:0]          ring_q;
  logic                cfg_wr;
  noc_rc_pkg::cfg_t    cfg;
  logic [8:0]          ring_min;
  logic [8:0]          div_a;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scheme_q <= noc_rc_pkg::SCHEME_MESH;
      own_q    <= 8'd0;
      grid_q   <= 5'd4;
      ring_q   <= 9'd4;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        noc_rc_pkg::REG_SCHEME: scheme_q <= noc_rc_pkg::scheme_e'(pwdata[1:0]);
        noc_rc_pkg::REG_OWN:    own_q    <= pwdata[7:0];
        noc_rc_pkg::REG_GRID:   grid_q   <= pwdata[4:0];
        noc_rc_pkg::REG_RING:   ring_q   <= pwdata[8:0];
        default:                ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      noc_rc_pkg::REG_SCHEME: prdata = {30'd0, scheme_q};
      noc_rc_pkg::REG_OWN:    prdata = {24'd0, own_q};
      noc_rc_pkg::REG_GRID:   prdata = {27'd0, grid_q};
      noc_rc_pkg::REG_RING:   prdata = {23'd0, ring_q};
      default:                prdata = '0;
    endcase
  end

  // zero size counts as one; ring saturates at the node limit
  assign ring_min = (ring_q == '0) ? 9'd1 : ring_q;
  assign cfg.scheme   = scheme_q;
  assign cfg.own_node = own_q;
  assign cfg.grid     = (grid_q == '0) ? 9'd1 : {4'd0, grid_q};
  assign cfg.ring     = ({2'b00, ring_min} > MaxNodes) ? MaxNodes[8:0] : ring_min;
  assign div_a        = (scheme_q == noc_rc_pkg::SCHEME_RING) ? cfg.ring : cfg.grid;

  // ---------------------------------------------------------------- flow
  logic     v1_q, v2_q, v3_q, v4_q, out_valid_q;
  logic     ld1, ld2, ld3, ld4, ld_out;
  stage_a_t st1_d, st1_q;
  stage_q_t st2_d, st2_q;
  stage_b_t st3_d, st3_q, st4_d, st4_q;
  logic [3:0] own_ql, dest_ql;
  noc_rc_pkg::route_t  route;
  noc_rc_pkg::result_t res_d, res_q;

  assign ld_out     = !out_valid_q || !out_stall_i;
  assign ld4        = !v4_q || ld_out;
  assign ld3        = !v3_q || ld4;
  assign ld2        = !v2_q || ld3;
  assign ld1        = !v1_q || ld2;
  assign in_stall_o = !ld1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ld1)    v1_q        <= in_valid_i;
      if (ld2)    v2_q        <= v1_q;
      if (ld3)    v3_q        <= v2_q;
      if (ld4)    v4_q        <= v3_q;
      if (ld_out) out_valid_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1)    st1_q <= st1_d;
    if (ld2)    st2_q <= st2_d;
    if (ld3)    st3_q <= st3_d;
    if (ld4)    st4_q <= st4_d;
    if (ld_out) res_q <= res_d;
  end

  // stage 1: high nibble of node / divisor
  assign st1_d.req = '{op_mode: op_mode_i, in_channel: in_channel_i,
                       dest_node: dest_node_i, is_response: is_response_i,
                       is_proc_request: is_proc_request_i};

  noc_rc_div4 u_div_a_hi_own (
    .rem_i(9'd0), .bits_i(own_q[7:4]), .divisor_i(div_a),
    .rem_o(st1_d.own_rem), .quo_o(st1_d.own_qh)
  );
  noc_rc_div4 u_div_a_hi_dst (
    .rem_i(9'd0), .bits_i(dest_node_i[7:4]), .divisor_i(div_a),
    .rem_o(st1_d.dest_rem), .quo_o(st1_d.dest_qh)
  );

  // stage 2: low nibble
  noc_rc_div4 u_div_a_lo_own (
    .rem_i(st1_q.own_rem), .bits_i(own_q[3:0]), .divisor_i(div_a),
    .rem_o(st2_d.div.own_rem), .quo_o(own_ql)
  );
  noc_rc_div4 u_div_a_lo_dst (
    .rem_i(st1_q.dest_rem), .bits_i(st1_q.req.dest_node[3:0]), .divisor_i(div_a),
    .rem_o(st2_d.div.dest_rem), .quo_o(dest_ql)
  );
  assign st2_d.req          = st1_q.req;
  assign st2_d.div.own_quo  = {st1_q.own_qh, own_ql};
  assign st2_d.div.dest_quo = {st1_q.dest_qh, dest_ql};

  // stages 3 and 4: row number modulo grid, for the torus Y mirror
  assign st3_d.req = st2_q.req;
  assign st3_d.div = st2_q.div;
  noc_rc_div4 u_div_b_hi_own (
    .rem_i(9'd0), .bits_i(st2_q.div.own_quo[7:4]), .divisor_i(cfg.grid),
    .rem_o(st3_d.own_rem_b), .quo_o()
  );
  noc_rc_div4 u_div_b_hi_dst (
    .rem_i(9'd0), .bits_i(st2_q.div.dest_quo[7:4]), .divisor_i(cfg.grid),
    .rem_o(st3_d.dest_rem_b), .quo_o()
  );

  assign st4_d.req = st3_q.req;
  assign st4_d.div = st3_q.div;
  noc_rc_div4 u_div_b_lo_own (
    .rem_i(st3_q.own_rem_b), .bits_i(st3_q.div.own_quo[3:0]), .divisor_i(cfg.grid),
    .rem_o(st4_d.own_rem_b), .quo_o()
  );
  noc_rc_div4 u_div_b_lo_dst (
    .rem_i(st3_q.dest_rem_b), .bits_i(st3_q.div.dest_quo[3:0]), .divisor_i(cfg.grid),
    .rem_o(st4_d.dest_rem_b), .quo_o()
  );

  // stage 5: route selection, entry update, result register
  noc_rc_route u_route (
    .cfg_i(cfg), .req_i(st4_q.req), .div_i(st4_q.div),
    .own_rem_b_i(st4_q.own_rem_b), .dest_rem_b_i(st4_q.dest_rem_b),
    .route_o(route)
  );

  noc_rc_table #(.NUM_VCS(NUM_VCS)) u_table (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .commit_i(v4_q && ld_out),
    .req_i(st4_q.req), .route_i(route),
    .result_o(res_d)
  );

  assign out_valid_o   = out_valid_q;
  assign egress_port_o = res_q.egress_port;
  assign out_vc_o      = res_q.out_vc;
  assign entry_valid_o = res_q.entry_valid;
  assign route_error_o = res_q.route_error;
  assign none_valid_o  = res_q.none_valid;

endmodule

>>> rtl/noc_rc_checker.sv
// ----------------------------------------------------------------------------
// noc_rc_checker
// Port-level checks of the route computation unit, bound to the top level.
// ----------------------------------------------------------------------------
module noc_rc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_i,
  input logic       out_valid_i,
  input logic       out_stall_i,
  input logic [2:0] egress_port_i,
  input logic [2:0] out_vc_i,
  input logic       entry_valid_i,
  input logic       route_error_i,
  input logic       none_valid_i
);

  // a result waiting under stall stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(egress_port_i) &&
    $stable(out_vc_i) && $stable(entry_valid_i) && $stable(route_error_i) &&
    $stable(none_valid_i))
    else $error("result changed while stalled");

  // with the output register empty the pipeline must take a request
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> !in_stall_i)
    else $error("request stalled with empty output");

  // an entry that never held a route reads as cleared
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !entry_valid_i |-> egress_port_i == 3'd0 && out_vc_i == 3'd0)
    else $error("invalid entry carries a route");

  a_valid_not_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && entry_valid_i |-> !none_valid_i)
    else $error("valid entry but none_valid set");

endmodule

bind noc_route_compute_unit noc_rc_checker u_noc_rc_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_stall_i(in_stall_o),
  .out_valid_i(out_valid_o),
  .out_stall_i(out_stall_i),
  .egress_port_i(egress_port_o),
  .out_vc_i(out_vc_o),
  .entry_valid_i(entry_valid_o),
  .route_error_i(route_error_o),
  .none_valid_i(none_valid_o)
);
